@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define DEQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// next-cycle implication, disabled while reset is held
`define DEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`endif

@@ hw/rtl/deq_pkg.sv @@
// deque package: operation and status codes, fixed field widths, result struct
// no dependencies
`timescale 1ns / 1ps

package deq_pkg;

  localparam int FUNC_W   = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_PUSH_REAR  = 2'd1;
  localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [FUNC_W-1:0] OP_POP_REAR   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic                is_empty;
    logic                is_full;
    logic                pop_ok;
  } deq_res_t;

endpackage

@@ hw/rtl/double_ended_queue.sv @@
// double-ended queue top level: control plus entry ram
// depends on deq_pkg, deq_ctrl, deq_mem
`timescale 1ns / 1ps

// Double-ended queue of WORD_WIDTH-bit words in a ring of DEPTH entries.
// Request channel: drive in_func and in_data_in with start high; the request
// is taken at an edge where start is high and busy is low. in_func selects
// push front, push rear, pop front or pop rear; in_data_in is ignored on pops.
// Result channel: out_valid is high for exactly one cycle per request, registered
// at the edge that ends the busy cycle, carrying out_data_out (popped word, else
// zero), out_status (done, underflow, overflow) and the empty/full flags
// after the operation. The receiver has no way to hold a result back.
// A new request is taken only once busy is low again. The edge after acceptance
// does the ram access and the index update and registers the result beside the
// ram's registered read; busy is high for a single cycle, up to that edge.
// A pop of an empty deque and a push to a full one change nothing.
// Reset (rst_n low, synchronous) empties the deque and drops any request in
// flight; ram contents are left as they are and never read before written.

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [DATA_W-1:0]   in_data_in,
  output logic                out_valid,
  output logic [DATA_W-1:0]   out_data_out,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_is_empty,
  output logic                out_is_full
);

  localparam int IW = $clog2(DEPTH);

  logic                  mem_we, mem_re;
  logic [IW-1:0]         mem_addr;
  logic [WORD_WIDTH-1:0] mem_wdata, mem_rdata;
  logic [63:0]           rdata_ext;
  deq_res_t              res;

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_func    (in_func),
    .in_data_in (in_data_in),
    .busy       (busy),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .res        (res)
  );

  deq_mem #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign rdata_ext    = 64'(mem_rdata);
  assign out_valid    = res.valid;
  assign out_data_out = res.pop_ok ? rdata_ext[DATA_W-1:0] : '0;
  assign out_status   = res.status;
  assign out_is_empty = res.is_empty;
  assign out_is_full  = res.is_full;

endmodule

@@ hw/rtl/deq_mem.sv @@
// deque entry store: single-port synchronous ram with registered read
// depends on nothing but its parameters
`timescale 1ns / 1ps

module deq_mem #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WORD_WIDTH-1:0]    wdata,
  output logic [WORD_WIDTH-1:0]    rdata
);

  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/deq_ctrl.sv @@
// deque control: request register, front index and count, ring address math
// depends on deq_pkg; drives deq_mem
`timescale 1ns / 1ps

module deq_ctrl
  import deq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic [DATA_W-1:0]          in_data_in,
  output logic                       busy,
  output logic                       mem_we,
  output logic                       mem_re,
  output logic [$clog2(DEPTH)-1:0]   mem_addr,
  output logic [WORD_WIDTH-1:0]      mem_wdata,
  output deq_res_t                   res
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  localparam logic [IW-1:0] IDX_LAST  = IW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);
  localparam logic [SW-1:0] SUM_DEPTH = SW'(DEPTH);

  logic                busy_r;
  logic [FUNC_W-1:0]   func_r;
  logic [DATA_W-1:0]   data_r;
  logic [IW-1:0]       front_r, front_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  deq_res_t            res_r, res_nxt;

  logic                accept;
  logic [IW-1:0]       front_dec, front_inc, rear_pos;
  logic [CW-1:0]       rear_off;
  logic [SW-1:0]       rear_sum;
  logic [63:0]         data_ext;
  logic                is_full, is_empty;

  assign accept = start & ~busy_r;

  assign front_dec = (front_r == '0) ? IDX_LAST : front_r - 1'b1;
  assign front_inc = (front_r == IDX_LAST) ? '0 : front_r + 1'b1;

  // rear push lands one past the last entry, rear pop takes the last entry
  assign rear_off = (func_r == OP_PUSH_REAR) ? count_r : count_r - 1'b1;
  assign rear_sum = SW'(front_r) + SW'(rear_off);
  assign rear_pos = (rear_sum >= SUM_DEPTH) ? IW'(rear_sum - SUM_DEPTH) : IW'(rear_sum);

  assign is_full  = (count_r == CNT_FULL);
  assign is_empty = (count_r == '0);

  assign data_ext  = 64'(data_r);
  assign mem_wdata = data_ext[WORD_WIDTH-1:0];

  always_comb begin
    front_nxt       = front_r;
    count_nxt       = count_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_addr        = front_r;
    res_nxt.valid   = busy_r;
    res_nxt.status  = ST_DONE;
    res_nxt.pop_ok  = 1'b0;
    unique case (func_r)
      OP_PUSH_FRONT: begin
        mem_addr = front_dec;
        if (is_full) begin
          res_nxt.status = ST_OVERFLOW;
        end else begin
          mem_we    = busy_r;
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_PUSH_REAR: begin
        mem_addr = rear_pos;
        if (is_full) begin
          res_nxt.status = ST_OVERFLOW;
        end else begin
          mem_we    = busy_r;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        mem_addr = front_r;
        if (is_empty) begin
          res_nxt.status = ST_UNDERFLOW;
        end else begin
          mem_re         = busy_r;
          res_nxt.pop_ok = 1'b1;
          front_nxt      = front_inc;
          count_nxt      = count_r - 1'b1;
        end
      end
      OP_POP_REAR: begin
        mem_addr = rear_pos;
        if (is_empty) begin
          res_nxt.status = ST_UNDERFLOW;
        end else begin
          mem_re         = busy_r;
          res_nxt.pop_ok = 1'b1;
          count_nxt      = count_r - 1'b1;
        end
      end
      default: begin
        mem_addr = front_r;
      end
    endcase
    res_nxt.is_empty = (count_nxt == '0);
    res_nxt.is_full  = (count_nxt == CNT_FULL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      front_r <= '0;
      count_r <= '0;
      res_r   <= '0;
    end else begin
      busy_r <= accept;
      res_r  <= res_nxt;
      if (busy_r) begin
        front_r <= front_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      data_r <= in_data_in;
    end
  end

  assign busy = busy_r;
  assign res  = res_r;

endmodule

@@ hw/rtl/deq_checker.sv @@
// port-level checker for the double-ended queue, bound to the top level
// depends on deq_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module deq_checker
  import deq_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [DATA_W-1:0]   out_data_out,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_is_empty,
  input logic                out_is_full
);

  // a taken request raises busy in the next cycle, which holds off further requests
  `DEQ_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // every busy cycle is followed by a result strobe, which never comes while busy
  `DEQ_ASSERT_NXT(a_busy_result, clk, rst_n, busy, out_valid)
  `DEQ_ASSERT_NOW(a_result_not_busy, clk, rst_n, out_valid, !busy)
  // underflow leaves the deque empty and returns no word
  `DEQ_ASSERT_NOW(a_underflow_empty, clk, rst_n,
    out_valid && out_status == ST_UNDERFLOW, out_is_empty && out_data_out == '0)
  // overflow only on a full deque, which cannot also be empty
  `DEQ_ASSERT_NOW(a_overflow_full, clk, rst_n,
    out_valid && out_status == ST_OVERFLOW, out_is_full && !out_is_empty)

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_data_out (out_data_out),
  .out_status   (out_status),
  .out_is_empty (out_is_empty),
  .out_is_full  (out_is_full)
);
